// File: hdl/rmfb_pkg.sv
// ----------------------------------------------------------------------------
// rmfb_pkg
// Shared types and codes of the rotated one-bit frame store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmfb_pkg;

   typedef logic [1:0] act_type;

   localparam act_type ACT_PLOT = 2'd0;
   localparam act_type ACT_FILL = 2'd1;
   localparam act_type ACT_READ = 2'd2;
   localparam act_type ACT_NONE = 2'd3;

   typedef logic [1:0] rot_type;

   localparam rot_type ROT_0   = 2'd0;
   localparam rot_type ROT_90  = 2'd1;
   localparam rot_type ROT_180 = 2'd2;
   localparam rot_type ROT_270 = 2'd3;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_ROTATION = 2'd0;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic       last;
      logic [7:0] pixels;
   } rsp_entry_type;

endpackage

`default_nettype wire

// File: hdl/rmfb_ram.sv
// ----------------------------------------------------------------------------
// rmfb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/rotated_mono_framebuffer.sv
// ----------------------------------------------------------------------------
// rotated_mono_framebuffer
// One-bit-per-pixel frame store with plot, fill and panel-order byte readout.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports   | content
//  --------+-----------+---------+------------------------------------------
//  req     | in        | req_t*  | tuser action, tdata pos_x/pos_y/colour
//  rsp     | out       | rsp_t*  | tdata inverted byte, tlast end of frame
//  csr     | in/out    | csr_p*  | rotation register at byte address 0
//
//  Plot and read requests are taken one per cycle while req_tready is high; a
//  read result passes stage 1 and stage 2 into a four-entry result queue.
//  Frame memory is one read-modify-write pipeline; back-to-back plots to the
//  same byte are forwarded from the last write.
//  Reset and every fill run a sweep over all ROW_BYTES*PANEL_HEIGHT bytes
//  (76800 by default), one byte a cycle, with no request taken.
//  req_tready drops while a fill is in flight and when the queue could fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotated_mono_framebuffer #(
   parameter int PANEL_WIDTH  = 960,
   parameter int PANEL_HEIGHT = 640
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [15:0] pos_x, [31:16] pos_y, [32] color_white, [39:33] zero
   input  wire logic [rmfb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] action
   input  wire logic [1:0]                          req_tuser,
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] pixel_byte
   output logic      [rmfb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tlast,
   // configuration
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rmfb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [rmfb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [rmfb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int PXW         = $clog2(PANEL_WIDTH);
   localparam int PYW         = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
   localparam int CW          = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   // ---------------------------------------------------------------- csr
   rmfb_pkg::rot_type rotation_ff, rotation_in;

   assign csr_pready = 1'b1;

   always_comb begin
      rotation_in = rotation_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && (csr_paddr == rmfb_pkg::REG_ROTATION)) begin
         rotation_in = csr_pwdata[1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == rmfb_pkg::REG_ROTATION) begin
         csr_prdata = {{(rmfb_pkg::CSR_DATA_W-2){1'b0}}, rotation_ff};
      end
   end

   // ---------------------------------------------------------------- state
   logic                      s1_valid_ff, s1_valid_in;
   rmfb_pkg::act_type         s1_op_ff, s1_op_in;
   logic [PXW-1:0]            s1_px_ff, s1_px_in;
   logic [PYW-1:0]            s1_py_ff, s1_py_in;
   logic                      s1_white_ff, s1_white_in;

   logic                      s2_valid_ff, s2_valid_in;
   rmfb_pkg::act_type         s2_op_ff, s2_op_in;
   logic [AW-1:0]             s2_addr_ff, s2_addr_in;
   logic [7:0]                s2_mask_ff, s2_mask_in;
   logic                      s2_white_ff, s2_white_in;
   logic                      s2_last_ff, s2_last_in;

   logic [PYW-1:0]            read_row_ff, read_row_in;
   logic [CW-1:0]             read_col_ff, read_col_in;

   logic                      sweep_ff, sweep_in;
   logic [AW-1:0]             sweep_addr_ff, sweep_addr_in;
   logic                      sweep_black_ff, sweep_black_in;

   logic                      wr_valid_ff, wr_valid_in;
   logic [AW-1:0]             wr_addr_ff, wr_addr_in;
   logic [7:0]                wr_data_ff, wr_data_in;

   rmfb_pkg::rsp_entry_type   rsp_q_ff [rmfb_pkg::RSP_DEPTH];
   logic [rmfb_pkg::RSP_PTR_W-1:0] rsp_wp_ff, rsp_wp_in;
   logic [rmfb_pkg::RSP_PTR_W-1:0] rsp_rp_ff, rsp_rp_in;
   logic [rmfb_pkg::RSP_CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // ---------------------------------------------------------------- accept
   logic                      accept;
   logic [rmfb_pkg::RSP_CNT_W-1:0] reads_pending;
   logic                      fill_pending;
   logic [15:0]               in_x, in_y;
   logic                      x_ok, y_ok;
   logic [PXW-1:0]            map_px;
   logic [PYW-1:0]            map_py;

   assign in_x = req_tdata[15:0];
   assign in_y = req_tdata[31:16];

   assign reads_pending = rsp_cnt_ff
      + rmfb_pkg::RSP_CNT_W'(s1_valid_ff && (s1_op_ff == rmfb_pkg::ACT_READ))
      + rmfb_pkg::RSP_CNT_W'(s2_valid_ff && (s2_op_ff == rmfb_pkg::ACT_READ));

   assign fill_pending = (s1_valid_ff && (s1_op_ff == rmfb_pkg::ACT_FILL))
                      || (s2_valid_ff && (s2_op_ff == rmfb_pkg::ACT_FILL));

   assign req_tready = !sweep_ff && !fill_pending
                    && (reads_pending < rmfb_pkg::RSP_CNT_W'(rmfb_pkg::RSP_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (rotation_ff[0]) begin
         x_ok = !in_x[15] && (in_x < 16'(PANEL_HEIGHT));
         y_ok = !in_y[15] && (in_y < 16'(PANEL_WIDTH));
      end else begin
         x_ok = !in_x[15] && (in_x < 16'(PANEL_WIDTH));
         y_ok = !in_y[15] && (in_y < 16'(PANEL_HEIGHT));
      end
   end

   always_comb begin
      case (rotation_ff)
         rmfb_pkg::ROT_90: begin
            map_px = PXW'(PANEL_WIDTH - 1) - in_y[PXW-1:0];
            map_py = in_x[PYW-1:0];
         end
         rmfb_pkg::ROT_180: begin
            map_px = PXW'(PANEL_WIDTH - 1) - in_x[PXW-1:0];
            map_py = PYW'(PANEL_HEIGHT - 1) - in_y[PYW-1:0];
         end
         rmfb_pkg::ROT_270: begin
            map_px = in_y[PXW-1:0];
            map_py = PYW'(PANEL_HEIGHT - 1) - in_x[PYW-1:0];
         end
         default: begin
            map_px = in_x[PXW-1:0];
            map_py = in_y[PYW-1:0];
         end
      endcase
   end

   always_comb begin
      s1_valid_in = accept;
      s1_op_in    = req_tuser;
      s1_px_in    = map_px;
      s1_py_in    = map_py;
      s1_white_in = req_tdata[32];
      // drop plots outside the rotated logical frame
      if ((req_tuser == rmfb_pkg::ACT_PLOT) && !(x_ok && y_ok)) begin
         s1_op_in = rmfb_pkg::ACT_NONE;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [PYW-1:0]            row_sel;
   logic [CW-1:0]             col_sel;
   logic [AW-1:0]             rd_addr;
   logic                      s1_read;
   logic                      row_end;

   assign s1_read = s1_valid_ff && (s1_op_ff == rmfb_pkg::ACT_READ);
   assign row_end = (read_col_ff == CW'(ROW_BYTES - 1));

   always_comb begin
      if (s1_op_ff == rmfb_pkg::ACT_READ) begin
         row_sel = read_row_ff;
         col_sel = read_col_ff;
      end else begin
         row_sel = s1_py_ff;
         col_sel = CW'(s1_px_ff >> 3);
      end
   end

   assign rd_addr = AW'(row_sel) * AW'(ROW_BYTES) + AW'(col_sel);

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_op_in    = s1_op_ff;
      s2_addr_in  = rd_addr;
      s2_mask_in  = 8'h80 >> s1_px_ff[2:0];
      s2_white_in = s1_white_ff;
      s2_last_in  = (read_row_ff == '0) && row_end;
   end

   always_comb begin
      read_row_in = read_row_ff;
      read_col_in = read_col_ff;
      if (s1_read) begin
         if (row_end) begin
            read_col_in = '0;
            if (read_row_ff == '0) begin
               read_row_in = PYW'(PANEL_HEIGHT - 1);
            end else begin
               read_row_in = read_row_ff - 1'b1;
            end
         end else begin
            read_col_in = read_col_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic [7:0]                rd_data;
   logic [7:0]                cur_byte;
   logic [7:0]                new_byte;
   logic                      s2_plot;
   logic                      s2_read;
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [7:0]                ram_wdata;

   assign s2_plot = s2_valid_ff && (s2_op_ff == rmfb_pkg::ACT_PLOT);
   assign s2_read = s2_valid_ff && (s2_op_ff == rmfb_pkg::ACT_READ);

   assign cur_byte = (wr_valid_ff && (wr_addr_ff == s2_addr_ff)) ? wr_data_ff : rd_data;
   assign new_byte = s2_white_ff ? (cur_byte & ~s2_mask_ff) : (cur_byte | s2_mask_ff);

   always_comb begin
      wr_valid_in = s2_plot;
      wr_addr_in  = s2_addr_ff;
      wr_data_in  = new_byte;
   end

   always_comb begin
      if (sweep_ff) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_addr_ff;
         ram_wdata = {8{sweep_black_ff}};
      end else begin
         ram_we    = s2_plot;
         ram_waddr = s2_addr_ff;
         ram_wdata = new_byte;
      end
   end

   rmfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- sweep
   always_comb begin
      sweep_in       = sweep_ff;
      sweep_addr_in  = sweep_addr_ff;
      sweep_black_in = sweep_black_ff;
      if (sweep_ff) begin
         if (sweep_addr_ff == AW'(STORE_BYTES - 1)) begin
            sweep_in = 1'b0;
         end else begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
         end
      end else if (s2_valid_ff && (s2_op_ff == rmfb_pkg::ACT_FILL)) begin
         sweep_in       = 1'b1;
         sweep_addr_in  = '0;
         sweep_black_in = !s2_white_ff;
      end
   end

   // ---------------------------------------------------------------- results
   logic rsp_pop;

   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (rsp_cnt_ff != '0);
   assign rsp_tdata  = rsp_q_ff[rsp_rp_ff].pixels;
   assign rsp_tlast  = rsp_q_ff[rsp_rp_ff].last;

   always_comb begin
      rsp_wp_in  = rsp_wp_ff + rmfb_pkg::RSP_PTR_W'(s2_read);
      rsp_rp_in  = rsp_rp_ff + rmfb_pkg::RSP_PTR_W'(rsp_pop);
      rsp_cnt_in = rsp_cnt_ff + rmfb_pkg::RSP_CNT_W'(s2_read)
                 - rmfb_pkg::RSP_CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (s2_read) begin
         rsp_q_ff[rsp_wp_ff] <= '{last: s2_last_ff, pixels: ~cur_byte};
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff    <= rmfb_pkg::ROT_0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         read_row_ff    <= PYW'(PANEL_HEIGHT - 1);
         read_col_ff    <= '0;
         sweep_ff       <= 1'b1;
         sweep_addr_ff  <= '0;
         sweep_black_ff <= 1'b0;
         wr_valid_ff    <= 1'b0;
         rsp_wp_ff      <= '0;
         rsp_rp_ff      <= '0;
         rsp_cnt_ff     <= '0;
      end else begin
         rotation_ff    <= rotation_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         read_row_ff    <= read_row_in;
         read_col_ff    <= read_col_in;
         sweep_ff       <= sweep_in;
         sweep_addr_ff  <= sweep_addr_in;
         sweep_black_ff <= sweep_black_in;
         wr_valid_ff    <= wr_valid_in;
         rsp_wp_ff      <= rsp_wp_in;
         rsp_rp_ff      <= rsp_rp_in;
         rsp_cnt_ff     <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_px_ff    <= s1_px_in;
      s1_py_ff    <= s1_py_in;
      s1_white_ff <= s1_white_in;
      s2_op_ff    <= s2_op_in;
      s2_addr_ff  <= s2_addr_in;
      s2_mask_ff  <= s2_mask_in;
      s2_white_ff <= s2_white_in;
      s2_last_ff  <= s2_last_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
   end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotated one-bit frame store. A short table
// of requests covers reset contents, fills, clipping at every edge and all
// four rotations. Random phases follow, one per rotation, mostly plotting
// just ahead of the readout pointer so that reads see the pixels. Every byte
// read out is checked: directed reads against table values, the rest against
// a bit-accurate model of the frame held in the bench.
// ----------------------------------------------------------------------------

module tb;

   localparam int PANEL_WIDTH   = 960;
   localparam int PANEL_HEIGHT  = 640;
   localparam int ROW_BYTES     = (PANEL_WIDTH + 7) / 8;
   localparam int STORE_BYTES   = ROW_BYTES * PANEL_HEIGHT;
   localparam int PHASE_ITEMS   = 110;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 10;
   localparam int DIRECTED_ROWS = 24;

   typedef struct packed {
      logic [7:0] pixels;
      logic       last;
   } readout_byte_type;

   typedef struct packed {
      rmfb_pkg::rot_type  rot;
      rmfb_pkg::act_type  act;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               white;
      logic               typed;
      logic [7:0]         pixels;
      logic               last;
   } stim_row_type;

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   // [15:0] pos_x, [31:16] pos_y, [32] color_white, [39:33] zero
   logic [rmfb_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   // [1:0] action
   logic [1:0]                      req_tuser   = rmfb_pkg::ACT_NONE;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   // [7:0] pixel_byte
   logic [rmfb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [rmfb_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [rmfb_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [rmfb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   rotated_mono_framebuffer #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // frame model
   logic [7:0]        panel_bits [STORE_BYTES];
   int                scan_row = PANEL_HEIGHT - 1;
   int                scan_col = 0;
   rmfb_pkg::rot_type rot_now  = rmfb_pkg::ROT_0;
   readout_byte_type  readout_due [$];

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int mismatches      = 0;
   int bytes_checked   = 0;
   int plots_sent      = 0;
   int fills_sent      = 0;
   int reads_sent      = 0;

   stim_row_type directed_rows [DIRECTED_ROWS];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      foreach (panel_bits[i]) panel_bits[i] = 8'h00;
   end

   task automatic flag_mismatch(string what, int expected_val, int got_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s expected %0h got %0h", $realtime, what, expected_val, got_val);
   endtask

   function automatic bit model_request(rmfb_pkg::act_type act, logic signed [15:0] x16,
                                        logic signed [15:0] y16, logic white,
                                        output readout_byte_type res);
      int x;
      int y;
      int lw;
      int lh;
      int px;
      int py;
      int idx;
      logic [7:0] mask;
      x   = x16;
      y   = y16;
      res = '0;
      case (act)
         rmfb_pkg::ACT_PLOT: begin
            lw = rot_now[0] ? PANEL_HEIGHT : PANEL_WIDTH;
            lh = rot_now[0] ? PANEL_WIDTH : PANEL_HEIGHT;
            if (x < 0 || x >= lw || y < 0 || y >= lh) return 1'b0;
            case (rot_now)
               rmfb_pkg::ROT_90: begin
                  px = PANEL_WIDTH - 1 - y;
                  py = x;
               end
               rmfb_pkg::ROT_180: begin
                  px = PANEL_WIDTH - 1 - x;
                  py = PANEL_HEIGHT - 1 - y;
               end
               rmfb_pkg::ROT_270: begin
                  px = y;
                  py = PANEL_HEIGHT - 1 - x;
               end
               default: begin
                  px = x;
                  py = y;
               end
            endcase
            idx  = py * ROW_BYTES + px / 8;
            mask = 8'h80 >> (px % 8);
            if (white) panel_bits[idx] = panel_bits[idx] & ~mask;
            else       panel_bits[idx] = panel_bits[idx] | mask;
            return 1'b0;
         end
         rmfb_pkg::ACT_FILL: begin
            foreach (panel_bits[i]) panel_bits[i] = white ? 8'h00 : 8'hFF;
            return 1'b0;
         end
         rmfb_pkg::ACT_READ: begin
            res.pixels = ~panel_bits[scan_row * ROW_BYTES + scan_col];
            res.last   = (scan_row == 0) && (scan_col == ROW_BYTES - 1);
            if (scan_col == ROW_BYTES - 1) begin
               scan_col = 0;
               scan_row = (scan_row == 0) ? PANEL_HEIGHT - 1 : scan_row - 1;
            end else begin
               scan_col++;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_request(rmfb_pkg::act_type act, logic signed [15:0] x = 0,
                               logic signed [15:0] y = 0, logic white = 1'b0,
                               logic typed = 1'b0, logic [7:0] typed_pixels = 8'h00,
                               logic typed_last = 1'b0);
      readout_byte_type due;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'b0, white, y, x};
      do @(posedge clock); while (!req_tready);
      case (act)
         rmfb_pkg::ACT_PLOT: plots_sent++;
         rmfb_pkg::ACT_FILL: fills_sent++;
         rmfb_pkg::ACT_READ: reads_sent++;
         default: ;
      endcase
      if (model_request(act, x, y, white, due)) begin
         if (typed) begin
            due.pixels = typed_pixels;
            due.last   = typed_last;
         end
         readout_due.push_back(due);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (readout_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rotation(rmfb_pkg::rot_type r);
      logic [31:0] noise;
      wait_for_drain();
      noise       = $urandom;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= rmfb_pkg::REG_ROTATION;
      csr_pwdata  <= {noise[31:2], r};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rot_now     = r;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[1:0] !== r)
         flag_mismatch("rotation readback", int'(r), int'(csr_prdata[1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(rmfb_pkg::rot_type r, int tx_idle, int rx_idle, bit may_fill);
      int i;
      int pick;
      int fill_at;
      int px;
      int py;
      int lw;
      int lh;
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic white;
      write_rotation(r);
      sender_idle_pct = tx_idle;
      stall_pct       = rx_idle;
      fill_at = (may_fill && $urandom_range(0, 1)) ? $urandom_range(0, PHASE_ITEMS - 1) : -1;
      lw = rot_now[0] ? PANEL_HEIGHT : PANEL_WIDTH;
      lh = rot_now[0] ? PANEL_WIDTH : PANEL_HEIGHT;
      for (i = 0; i < PHASE_ITEMS; i++) begin
         if (i == PHASE_ITEMS / 2) wait_for_drain();
         pick  = $urandom_range(0, 99);
         white = ($urandom_range(0, 9) < 3);
         if (i == fill_at) begin
            send_request(rmfb_pkg::ACT_FILL, 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
         end else if (pick < 40) begin
            send_request(rmfb_pkg::ACT_READ, 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
         end else if (pick < 78) begin
            // aim just ahead of the readout pointer
            py = (scan_row > 0 && $urandom_range(0, 3) == 0) ? scan_row - 1 : scan_row;
            px = (scan_col * 8 + $urandom_range(0, 127)) % PANEL_WIDTH;
            case (rot_now)
               rmfb_pkg::ROT_90: begin
                  lx = 16'(py);
                  ly = 16'(PANEL_WIDTH - 1 - px);
               end
               rmfb_pkg::ROT_180: begin
                  lx = 16'(PANEL_WIDTH - 1 - px);
                  ly = 16'(PANEL_HEIGHT - 1 - py);
               end
               rmfb_pkg::ROT_270: begin
                  lx = 16'(PANEL_HEIGHT - 1 - py);
                  ly = 16'(px);
               end
               default: begin
                  lx = 16'(px);
                  ly = 16'(py);
               end
            endcase
            send_request(rmfb_pkg::ACT_PLOT, lx, ly, white);
         end else if (pick < 90) begin
            send_request(rmfb_pkg::ACT_PLOT, 16'($urandom_range(0, lw - 1)),
                         16'($urandom_range(0, lh - 1)), white);
         end else if (pick < 97) begin
            send_request(rmfb_pkg::ACT_PLOT, 16'($urandom), 16'($urandom), white);
         end else begin
            send_request(rmfb_pkg::ACT_NONE, 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
         end
      end
      // close with a read so that a fill in flight is drained before the next write
      send_request(rmfb_pkg::ACT_READ);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin : check_readout
      readout_byte_type due;
      if (rsp_tvalid === 1'b1 && rsp_tready) begin
         if (readout_due.size() == 0) begin
            flag_mismatch("unexpected pixel_byte", 0, int'(rsp_tdata));
         end else begin
            due = readout_due.pop_front();
            bytes_checked++;
            if (rsp_tdata !== due.pixels)
               flag_mismatch("pixel_byte", int'(due.pixels), int'(rsp_tdata));
            if (rsp_tlast !== due.last)
               flag_mismatch("frame_last", int'(due.last), int'(rsp_tlast));
         end
      end
   end

   initial begin
      int i;
      directed_rows = '{
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_READ,      0,      0, 1'b0, 1'b1, 8'hFF, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_FILL,      0,      0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_READ,      0,      0, 1'b0, 1'b1, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_FILL,      0,      0, 1'b1, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_READ,      0,      0, 1'b0, 1'b1, 8'hFF, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT,     24,    639, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT,     25,    639, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT,     25,    639, 1'b1, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT, -32768, -32768, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT,  32767,  32767, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT,    960,      0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT,      0,    640, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_PLOT,     -1,      5, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_0, rmfb_pkg::ACT_NONE,     -1,     -1, 1'b1, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_90, rmfb_pkg::ACT_PLOT,   639,    927, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_90, rmfb_pkg::ACT_PLOT,   640,      0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_90, rmfb_pkg::ACT_PLOT,     0,    960, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_180, rmfb_pkg::ACT_PLOT,  919,      0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_270, rmfb_pkg::ACT_PLOT,    0,     55, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_270, rmfb_pkg::ACT_PLOT,  640,      0, 1'b0, 1'b0, 8'h00, 1'b0},
         '{rmfb_pkg::ROT_270, rmfb_pkg::ACT_READ,    0,      0, 1'b0, 1'b1, 8'h7F, 1'b0},
         '{rmfb_pkg::ROT_270, rmfb_pkg::ACT_READ,    0,      0, 1'b0, 1'b1, 8'h7F, 1'b0},
         '{rmfb_pkg::ROT_270, rmfb_pkg::ACT_READ,    0,      0, 1'b0, 1'b1, 8'h7F, 1'b0},
         '{rmfb_pkg::ROT_270, rmfb_pkg::ACT_READ,    0,      0, 1'b0, 1'b1, 8'hFE, 1'b0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_rotation(rmfb_pkg::ROT_0);
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].rot != rot_now) write_rotation(directed_rows[i].rot);
         send_request(directed_rows[i].act, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].white, directed_rows[i].typed,
                      directed_rows[i].pixels, directed_rows[i].last);
      end

      random_phase(rmfb_pkg::ROT_0, 0, 0, 1'b0);
      random_phase(rmfb_pkg::ROT_90, 46, 0, 1'b1);
      random_phase(rmfb_pkg::ROT_180, 0, 46, 1'b1);
      random_phase(rmfb_pkg::ROT_270, 15, 15, 1'b0);

      wait_for_drain();
      $display("Sent %0d plots, %0d fills and %0d reads over all four rotations;",
               plots_sent, fills_sent, reads_sent);
      $display("%0d bytes checked against the frame model under idle and stall phases.",
               bytes_checked);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
